@@ hdl/ost_pkg.sv @@
// Shared types, codes and field widths for the ordered sequence table.
`timescale 1ns / 1ps
`default_nettype none

package ost_pkg;

	// Default sizes of the store.
	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed widths of the request and response fields.
	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int RPOS_W    = 6;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT_AT     = 3'd0,
		OP_INSERT_SORTED = 3'd1,
		OP_ERASE         = 3'd2,
		OP_REMOVE_ALL    = 3'd3,
		OP_READ          = 3'd4,
		OP_WRITE         = 3'd5,
		OP_FIND          = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DOWN,
		S_PUT,
		S_RDWAIT,
		S_FINISH
	} state_t;

	// Flags from the shared compare unit.
	typedef struct packed {
		logic eq;
		logic le;
	} cmp_flags_t;

endpackage

`default_nettype wire

@@ hdl/ost_mem.sv @@
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ost_mem #(
	parameter int DEPTH = ost_pkg::CAPACITY_DEF,
	parameter int WIDTH = ost_pkg::VALUE_WIDTH_DEF,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	import ost_pkg::*;

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/ost_cmp.sv @@
// Shared compare unit: equality and signed less-or-equal of two values.
`timescale 1ns / 1ps
`default_nettype none

module ost_cmp #(
	parameter int WIDTH = ost_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output ost_pkg::cmp_flags_t   flags
);
	import ost_pkg::*;

	// Packed in field order: eq, then le.
	assign flags = {(a == b), ($signed(a) <= $signed(b))};

endmodule

`default_nettype wire

@@ hdl/ordered_sequence_table.sv @@
// Top level of the ordered sequence table: sequencer, store and result register.
// Read, write and rejected requests need no walk over the store; insert, erase, remove
// and find walk every entry that is scanned or moved before their response word is formed.
// One request is worked at a time; the pace is set by the single read port of the store,
// which walks one entry per cycle. A new request is taken while a response still waits.
// Reset clears the entry count, the sequencer and the response valid; the store itself is
// not cleared, since entries at or beyond the count are never used.
`timescale 1ns / 1ps
`default_nettype none

module ordered_sequence_table #(
	parameter int CAPACITY    = ost_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = ost_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Request channel.
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire logic [ost_pkg::OP_W-1:0]             operation,
	input  wire logic [ost_pkg::POS_W-1:0]            position,
	input  wire logic signed [ost_pkg::DATA_W-1:0]    item_value,
	// Response channel.
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output logic [ost_pkg::STATUS_W-1:0]              status,
	output logic [ost_pkg::RPOS_W-1:0]                result_position,
	output logic signed [ost_pkg::DATA_W-1:0]         read_value,
	output logic [ost_pkg::CNT_OUT_W-1:0]             removed_count,
	output logic [ost_pkg::CNT_OUT_W-1:0]             length
);
	import ost_pkg::*;

	// Address width of the store, width of a count that can hold CAPACITY itself,
	// and widths used to compare or resize against the fixed port fields.
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int RW = (AW > RPOS_W) ? AW : RPOS_W;
	localparam int LW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Sequencer state and the request being worked.
	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [POS_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          count_q;

	// Walk over the store: read index, last index to read, and the word in flight
	// from the registered read port together with its index.
	logic [AW-1:0]          rd_idx_q, last_q, pend_idx_q, ins_pos_q;
	logic                   rd_on_q, pend_q;
	logic [CW-1:0]          j_q;

	// Result of the request being worked.
	status_t                st_q;
	logic [AW-1:0]          rpos_q;
	logic [VALUE_WIDTH-1:0] rval_q;
	logic [CW-1:0]          rem_q;

	// Response register, which frees the sequencer for the next request.
	logic                   rsp_valid_q;
	status_t                status_o_q;
	logic [RPOS_W-1:0]      rpos_o_q;
	logic [DATA_W-1:0]      rval_o_q;
	logic [CNT_OUT_W-1:0]   rem_o_q;
	logic [CNT_OUT_W-1:0]   len_o_q;

	// Store and compare unit connections.
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
	cmp_flags_t             flags;

	// Derived request checks.
	logic signed [63:0]     iv_wide;
	logic [63:0]            rv_wide;
	logic [RW-1:0]          rp_wide;
	logic [LW-1:0]          rem_wide, len_wide;
	logic [XW-1:0]          pos_x, cnt_x;
	logic [AW-1:0]          pos_a, cnt_a, cnt_m1_a, idx_step;
	logic                   bad_ins, bad_acc, full, pos_eq_cnt, pos_last;
	logic                   scan_hit, scan_stop, run_done, out_free, walking;
	status_t                chk_status;

	// The request value is sign-extended and then held at the store width.
	assign iv_wide = 64'(item_value);
	assign rv_wide = 64'(rval_q);
	assign rp_wide = RW'(rpos_q);
	assign rem_wide = LW'(rem_q);
	assign len_wide = LW'(count_q);

	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);
	assign pos_a = AW'(pos_q);
	assign cnt_a = AW'(count_q);
	assign cnt_m1_a = AW'(count_q - 1'b1);

	// A positional insert may land just past the last entry; every other access
	// must hit an existing entry.
	assign bad_ins = (pos_x > cnt_x);
	assign bad_acc = (pos_x >= cnt_x);
	assign full = (count_q == CAP_C);
	assign pos_eq_cnt = (pos_x == cnt_x);
	assign pos_last = ((pos_x + 1'b1) == cnt_x);

	// The shift that opens a gap for an insert walks the store downward; scans and the erase shift walk upward.
	assign idx_step = (state_q == S_SHIFT_UP) ? AW'(rd_idx_q - 1'b1) : AW'(rd_idx_q + 1'b1);
	assign walking = (state_q == S_SCAN) || (state_q == S_SHIFT_UP) ||
		(state_q == S_SHIFT_DOWN);

	// A sorted insert stops at the first entry not below the value; a find stops
	// at the first equal entry.
	assign scan_hit = pend_q && (((op_q == OP_INSERT_SORTED) && flags.le) ||
		((op_q == OP_FIND) && flags.eq));
	assign scan_stop = (state_q == S_SCAN) && scan_hit;
	assign run_done = !rd_on_q && !pend_q;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Status of a request as decided by the checks on entry; insert_at checks the
	// position before the fill level.
	always_comb begin
		chk_status = ST_OK;
		case (op_q)
			OP_INSERT_AT: begin
				if (bad_ins) begin
					chk_status = ST_BAD_POS;
				end else if (full) begin
					chk_status = ST_FULL;
				end
			end
			OP_INSERT_SORTED: begin
				if (full) begin
					chk_status = ST_FULL;
				end
			end
			OP_ERASE, OP_READ, OP_WRITE: begin
				if (bad_acc) begin
					chk_status = ST_BAD_POS;
				end
			end
			default: begin
			end
		endcase
	end

	ost_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ost_cmp #(
		.WIDTH (VALUE_WIDTH)
	) u_cmp (
		.a     (val_q),
		.b     (mem_rdata),
		.flags (flags)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (op_q)
					OP_INSERT_AT: begin
						if (bad_ins || full) begin
							state_d = S_FINISH;
						end else if (pos_eq_cnt) begin
							state_d = S_PUT;
						end else begin
							state_d = S_SHIFT_UP;
						end
					end
					OP_INSERT_SORTED: state_d = full ? S_FINISH : S_SCAN;
					OP_ERASE:         state_d = bad_acc ? S_FINISH : S_SHIFT_DOWN;
					OP_REMOVE_ALL:    state_d = S_SCAN;
					OP_FIND:          state_d = S_SCAN;
					OP_READ:          state_d = bad_acc ? S_FINISH : S_RDWAIT;
					default:          state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = (op_q == OP_INSERT_SORTED) ? S_SHIFT_UP : S_FINISH;
				end else if (run_done) begin
					state_d = (op_q == OP_INSERT_SORTED) ? S_PUT : S_FINISH;
				end
			end
			S_SHIFT_UP: begin
				if (run_done) begin
					state_d = S_PUT;
				end
			end
			S_SHIFT_DOWN: begin
				if (run_done) begin
					state_d = S_FINISH;
				end
			end
			S_PUT:    state_d = S_FINISH;
			S_RDWAIT: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Store port control. The word read in one cycle is written back one place
	// up or down, or compacted, in the next.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_q;
		mem_wdata = val_q;
		mem_raddr = rd_idx_q;
		case (state_q)
			S_CHECK: begin
				mem_raddr = pos_a;
				if ((op_q == OP_WRITE) && !bad_acc) begin
					mem_we    = 1'b1;
					mem_waddr = pos_a;
				end
			end
			S_SCAN: begin
				if ((op_q == OP_REMOVE_ALL) && pend_q && !flags.eq) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(j_q);
					mem_wdata = mem_rdata;
				end
			end
			S_SHIFT_UP: begin
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pend_idx_q + 1'b1);
					mem_wdata = mem_rdata;
				end
			end
			S_SHIFT_DOWN: begin
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pend_idx_q - 1'b1);
					mem_wdata = mem_rdata;
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = ins_pos_q;
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_on_q     <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// A finished request fills the response register; otherwise a taken
			// response word empties it.
			if ((state_q == S_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// One step of the walk: issue the next read and mark the word in flight.
			// A hit in the scan of a sorted insert sets up its own next walk below; a hit in a find ends the walk.
			if (walking && !scan_stop) begin
				pend_q     <= rd_on_q;
				pend_idx_q <= rd_idx_q;
				if (rd_on_q) begin
					rd_idx_q <= idx_step;
					if (rd_idx_q == last_q) begin
						rd_on_q <= 1'b0;
					end
				end
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= op_t'(operation);
						pos_q <= position;
						val_q <= iv_wide[VALUE_WIDTH-1:0];
					end
				end
				S_CHECK: begin
					st_q      <= chk_status;
					rpos_q    <= '0;
					rval_q    <= '0;
					rem_q     <= '0;
					j_q       <= '0;
					pend_q    <= 1'b0;
					ins_pos_q <= pos_a;
					case (op_q)
						OP_INSERT_AT: begin
							rd_idx_q <= cnt_m1_a;
							last_q   <= pos_a;
							rd_on_q  <= !bad_ins && !full && !pos_eq_cnt;
						end
						OP_INSERT_SORTED: begin
							rd_idx_q <= '0;
							last_q   <= cnt_m1_a;
							rd_on_q  <= !full && (count_q != '0);
						end
						OP_REMOVE_ALL, OP_FIND: begin
							rd_idx_q <= '0;
							last_q   <= cnt_m1_a;
							rd_on_q  <= (count_q != '0);
						end
						OP_ERASE: begin
							rd_idx_q <= AW'(pos_a + 1'b1);
							last_q   <= cnt_m1_a;
							rd_on_q  <= !bad_acc && !pos_last;
						end
						default: begin
							rd_idx_q <= '0;
							last_q   <= cnt_m1_a;
							rd_on_q  <= 1'b0;
						end
					endcase
				end
				S_SCAN: begin
					// Remove keeps a write index that lags the read index by the
					// number of matches seen so far.
					if (pend_q && (op_q == OP_REMOVE_ALL)) begin
						if (flags.eq) begin
							rem_q <= CW'(rem_q + 1'b1);
						end else begin
							j_q <= CW'(j_q + 1'b1);
						end
					end
					if (scan_hit) begin
						if (op_q == OP_INSERT_SORTED) begin
							// Turn around and open a gap at the hit position.
							ins_pos_q <= pend_idx_q;
							rd_idx_q  <= cnt_m1_a;
							last_q    <= pend_idx_q;
							rd_on_q   <= 1'b1;
							pend_q    <= 1'b0;
						end else begin
							rpos_q <= pend_idx_q;
						end
					end else if (run_done) begin
						case (op_q)
							OP_INSERT_SORTED: ins_pos_q <= cnt_a;
							OP_REMOVE_ALL:    count_q   <= j_q;
							OP_FIND:          st_q      <= ST_NOT_FOUND;
							default: begin
							end
						endcase
					end
				end
				S_SHIFT_DOWN: begin
					if (run_done) begin
						count_q <= CW'(count_q - 1'b1);
					end
				end
				S_PUT: begin
					count_q <= CW'(count_q + 1'b1);
					rpos_q  <= ins_pos_q;
				end
				S_RDWAIT: begin
					rval_q <= mem_rdata;
				end
				S_FINISH: begin
					if (out_free) begin
						status_o_q  <= st_q;
						rpos_o_q    <= rp_wide[RPOS_W-1:0];
						rval_o_q    <= rv_wide[DATA_W-1:0];
						rem_o_q     <= rem_wide[CNT_OUT_W-1:0];
						len_o_q     <= len_wide[CNT_OUT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_o_q;
	assign result_position = rpos_o_q;
	assign read_value      = rval_o_q;
	assign removed_count   = rem_o_q;
	assign length          = len_o_q;

	// Placing a value always grows the sequence by exactly one entry.
	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("entry count did not grow after placing a value");

	// An erase shrinks the sequence by exactly one entry when its shift ends.
	a_erase_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_DOWN && run_done) |=> (count_q == CW'($past(count_q) - 1'b1)))
		else $error("entry count did not shrink after an erase");

	// The store is never written beyond the slot just past the last entry.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (XW'(mem_waddr) <= cnt_x))
		else $error("store written beyond the end of the sequence");

	// A finished request reaches the response register and frees the sequencer.
	a_finish_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished request did not reach the response register");

endmodule

`default_nettype wire
